/* rtl/mqtt_receive_deframer_keepalive_defines.svh */
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef MQTT_RECEIVE_DEFRAMER_KEEPALIVE_DEFINES_SVH
`define MQTT_RECEIVE_DEFRAMER_KEEPALIVE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MQTTRD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define MQTTRD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MQTTRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mqttrd_pkg.sv */
`timescale 1ns / 1ps

package mqttrd_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SENT    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_TOPIC     = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
  localparam logic [2:0] KIND_PINGREQ   = 3'd2;
  localparam logic [2:0] KIND_PINGRESP  = 3'd3;
  localparam logic [2:0] KIND_LINK_LOST = 3'd4;
  localparam logic [2:0] KIND_EMPTY_END = 3'd5;

  // MQTT control packet types (high nibble of the fixed header).
  localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
  localparam logic [3:0] TYPE_PINGREQ  = 4'hC;
  localparam logic [3:0] TYPE_PINGRESP = 4'hD;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_KEEPALIVE  = 2'd0;
  localparam logic [1:0] REG_MAX_PACKET = 2'd1;
  localparam logic [1:0] REG_MAX_TOPIC  = 2'd2;

  localparam logic [15:0] KEEPALIVE_RESET  = 16'd15;
  localparam logic [15:0] MAX_PACKET_RESET = 16'd128;
  localparam logic [15:0] MAX_TOPIC_RESET  = 16'd64;

  // Remaining length of a four digit varint.
  localparam int REM_W = 28;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] topic_length;
    logic        message_end;
  } result_t;

  // Events the parser hands to the keepalive supervisor.
  typedef struct packed {
    logic clear_in;
    logic ping_clear;
  } rx_evt_t;

  // Everything the keepalive supervisor needs for one transaction.
  typedef struct packed {
    logic    restart;
    logic    tick;
    logic    sent;
    rx_evt_t rx;
  } ka_evt_t;

endpackage

/* rtl/mqttrd_parser.sv */
`timescale 1ns / 1ps

module mqttrd_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  logic                    active,
  input  logic [7:0]              rx_byte,
  input  logic [15:0]             max_packet_bytes,
  input  logic [15:0]             max_topic_bytes,
  output mqttrd_pkg::result_t     res,
  output mqttrd_pkg::rx_evt_t     evt
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_DATA    = 3'd4,
    PH_BODY    = 3'd5
  } phase_t;

  localparam int RW = mqttrd_pkg::REM_W;

  phase_t        phase, phase_next;
  logic [3:0]    packet_kind, packet_kind_next;
  logic [2:0]    length_digits, length_digits_next;
  logic [RW-1:0] remaining_bytes, remaining_bytes_next;
  logic [15:0]   topic_len_held, topic_len_held_next;
  logic [15:0]   topic_bytes_left, topic_bytes_left_next;
  logic          discard_packet, discard_packet_next;

  logic [RW-1:0] rem_dec;
  logic [RW-1:0] rem_or;
  logic [RW:0]   total;
  logic [2:0]    digits_inc;
  logic [15:0]   tl_full;
  logic          over;
  logic          publish;

  assign rem_dec    = remaining_bytes - RW'(1);
  assign digits_inc = length_digits + 3'd1;
  assign tl_full    = {topic_len_held[15:8], rx_byte};
  assign publish    = (packet_kind == mqttrd_pkg::TYPE_PUBLISH);

  always_comb begin
    case (length_digits[1:0])
      2'd0:    rem_or = remaining_bytes | {21'd0, rx_byte[6:0]};
      2'd1:    rem_or = remaining_bytes | {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    rem_or = remaining_bytes | {7'd0, rx_byte[6:0], 14'd0};
      default: rem_or = remaining_bytes | {rx_byte[6:0], 21'd0};
    endcase
  end

  assign total = {1'b0, rem_or} + (RW+1)'(digits_inc) + (RW+1)'(1);
  assign over  = total > (RW+1)'(max_packet_bytes);

  always_comb begin
    phase_next            = phase;
    packet_kind_next      = packet_kind;
    length_digits_next    = length_digits;
    remaining_bytes_next  = remaining_bytes;
    topic_len_held_next   = topic_len_held;
    topic_bytes_left_next = topic_bytes_left;
    discard_packet_next   = discard_packet;
    res                   = '0;
    evt                   = '0;

    if (active) begin
      case (phase)
        PH_HEADER: begin
          packet_kind_next     = rx_byte[7:4];
          length_digits_next   = 3'd0;
          remaining_bytes_next = '0;
          discard_packet_next  = 1'b0;
          phase_next           = PH_LENGTH;
        end
        PH_LENGTH: begin
          remaining_bytes_next = rem_or;
          length_digits_next   = digits_inc;
          if (!rx_byte[7] || digits_inc[2]) begin
            discard_packet_next = over;
            if (rem_or == '0) begin
              phase_next = PH_HEADER;
              if (over) begin
                discard_packet_next = 1'b0;
              end else begin
                // A complete packet with no body.
                evt.clear_in = 1'b1;
                if (!publish) begin
                  if (packet_kind == mqttrd_pkg::TYPE_PINGREQ) begin
                    res.valid = 1'b1;
                    res.kind  = mqttrd_pkg::KIND_PINGRESP;
                  end
                  evt.ping_clear = (packet_kind == mqttrd_pkg::TYPE_PINGRESP);
                end
              end
            end else begin
              phase_next = (!over && publish) ? PH_TLEN_HI : PH_BODY;
            end
          end
        end
        PH_TLEN_HI: begin
          topic_len_held_next  = {rx_byte, 8'd0};
          remaining_bytes_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next   = PH_HEADER;
            evt.clear_in = 1'b1;
          end else begin
            phase_next = PH_TLEN_LO;
          end
        end
        PH_TLEN_LO: begin
          topic_len_held_next  = tl_full;
          remaining_bytes_next = rem_dec;
          if (tl_full > max_topic_bytes || RW'(tl_full) > rem_dec) begin
            if (rem_dec == '0) begin
              phase_next   = PH_HEADER;
              evt.clear_in = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end else if (rem_dec == '0) begin
            phase_next       = PH_HEADER;
            evt.clear_in     = 1'b1;
            res.valid        = 1'b1;
            res.kind         = mqttrd_pkg::KIND_EMPTY_END;
            res.topic_length = tl_full;
            res.message_end  = 1'b1;
          end else begin
            topic_bytes_left_next = tl_full;
            phase_next            = PH_DATA;
          end
        end
        PH_DATA: begin
          res.valid        = 1'b1;
          res.data_byte    = rx_byte;
          res.topic_length = topic_len_held;
          if (topic_bytes_left != 16'd0) begin
            res.kind              = mqttrd_pkg::KIND_TOPIC;
            topic_bytes_left_next = topic_bytes_left - 16'd1;
          end else begin
            res.kind = mqttrd_pkg::KIND_PAYLOAD;
          end
          remaining_bytes_next = rem_dec;
          if (rem_dec == '0) begin
            res.message_end = 1'b1;
            phase_next      = PH_HEADER;
            evt.clear_in    = 1'b1;
          end
        end
        PH_BODY: begin
          if (remaining_bytes != '0) begin
            remaining_bytes_next = rem_dec;
          end
          if (remaining_bytes <= RW'(1)) begin
            phase_next = PH_HEADER;
            if (discard_packet) begin
              discard_packet_next = 1'b0;
            end else begin
              evt.clear_in   = 1'b1;
              evt.ping_clear = (packet_kind == mqttrd_pkg::TYPE_PINGRESP);
              if (packet_kind == mqttrd_pkg::TYPE_PINGREQ) begin
                res.valid = 1'b1;
                res.kind  = mqttrd_pkg::KIND_PINGRESP;
              end
            end
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase            <= PH_HEADER;
      packet_kind      <= 4'd0;
      length_digits    <= 3'd0;
      remaining_bytes  <= '0;
      topic_len_held   <= 16'd0;
      topic_bytes_left <= 16'd0;
      discard_packet   <= 1'b0;
    end else begin
      phase            <= phase_next;
      packet_kind      <= packet_kind_next;
      length_digits    <= length_digits_next;
      remaining_bytes  <= remaining_bytes_next;
      topic_len_held   <= topic_len_held_next;
      topic_bytes_left <= topic_bytes_left_next;
      discard_packet   <= discard_packet_next;
    end
  end

endmodule

/* rtl/mqttrd_keepalive.sv */
`timescale 1ns / 1ps

module mqttrd_keepalive (
  input  logic                  clk,
  input  logic                  rst,
  input  mqttrd_pkg::ka_evt_t   evt,
  input  logic [15:0]           keepalive_seconds,
  output mqttrd_pkg::result_t   res,
  output logic                  link_down
);

  logic [15:0] seconds_since_in, seconds_since_in_next;
  logic [15:0] seconds_since_out, seconds_since_out_next;
  logic        ping_pending, ping_pending_next;
  logic        link_down_next;
  logic [15:0] in_inc;
  logic [15:0] out_inc;

  // Both idle counters saturate at full scale.
  assign in_inc  = (seconds_since_in == 16'hFFFF) ? seconds_since_in : seconds_since_in + 16'd1;
  assign out_inc = (seconds_since_out == 16'hFFFF) ? seconds_since_out
                                                   : seconds_since_out + 16'd1;

  always_comb begin
    seconds_since_in_next  = seconds_since_in;
    seconds_since_out_next = seconds_since_out;
    ping_pending_next      = ping_pending;
    link_down_next         = link_down;
    res                    = '0;

    if (evt.tick) begin
      seconds_since_in_next  = in_inc;
      seconds_since_out_next = out_inc;
      if (in_inc > keepalive_seconds || out_inc > keepalive_seconds) begin
        res.valid = 1'b1;
        if (ping_pending) begin
          link_down_next = 1'b1;
          res.kind       = mqttrd_pkg::KIND_LINK_LOST;
        end else begin
          seconds_since_in_next  = 16'd0;
          seconds_since_out_next = 16'd0;
          ping_pending_next      = 1'b1;
          res.kind               = mqttrd_pkg::KIND_PINGREQ;
        end
      end
    end
    if (evt.sent) begin
      seconds_since_out_next = 16'd0;
    end
    if (evt.rx.clear_in) begin
      seconds_since_in_next = 16'd0;
    end
    if (evt.rx.ping_clear) begin
      ping_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || evt.restart) begin
      seconds_since_in  <= 16'd0;
      seconds_since_out <= 16'd0;
      ping_pending      <= 1'b0;
      link_down         <= 1'b0;
    end else begin
      seconds_since_in  <= seconds_since_in_next;
      seconds_since_out <= seconds_since_out_next;
      ping_pending      <= ping_pending_next;
      link_down         <= link_down_next;
    end
  end

endmodule

/* rtl/mqtt_receive_deframer_keepalive.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  op, rx_byte
// out       output     out_valid / out_stall kind, data_byte, topic_length, message_end
// cfg       input      cfg_we (no wait)     cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_stall is low, the rate set by
// the single pass of parser and keepalive logic between the state registers and
// the output register; a result, if any, is registered there or in the skid register.
// Reset is synchronous and returns every parser and keepalive register to its idle
// value and the configuration registers to their defaults.
// A skid register behind the output register lets one more transaction in while a
// result waits; in_stall rises only when both are full.

`include "mqtt_receive_deframer_keepalive_defines.svh"

module mqtt_receive_deframer_keepalive (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] topic_length,
  output logic        message_end,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] keepalive_seconds;
  logic [15:0] max_packet_bytes;
  logic [15:0] max_topic_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive_seconds <= mqttrd_pkg::KEEPALIVE_RESET;
      max_packet_bytes  <= mqttrd_pkg::MAX_PACKET_RESET;
      max_topic_bytes   <= mqttrd_pkg::MAX_TOPIC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mqttrd_pkg::REG_KEEPALIVE:  keepalive_seconds <= cfg_data;
        mqttrd_pkg::REG_MAX_PACKET: max_packet_bytes  <= cfg_data;
        mqttrd_pkg::REG_MAX_TOPIC:  max_topic_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode of the accepted transaction. Once the link is declared lost, only a
  // restart has any effect.
  logic                accept;
  logic                link_down;
  logic                live;
  logic                rx_active;
  mqttrd_pkg::ka_evt_t ka_evt;
  mqttrd_pkg::rx_evt_t rx_evt;
  mqttrd_pkg::result_t par_res;
  mqttrd_pkg::result_t ka_res;
  mqttrd_pkg::result_t new_res;

  assign accept = in_valid && !in_stall;
  assign live   = accept && !link_down;

  always_comb begin
    rx_active      = 1'b0;
    ka_evt         = '0;
    case (op)
      mqttrd_pkg::OP_RX:      rx_active      = live;
      mqttrd_pkg::OP_TICK:    ka_evt.tick    = live;
      mqttrd_pkg::OP_SENT:    ka_evt.sent    = live;
      mqttrd_pkg::OP_RESTART: ka_evt.restart = accept;
      default: ;
    endcase
    ka_evt.rx = rx_evt;
  end

  mqttrd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .restart          (ka_evt.restart),
    .active           (rx_active),
    .rx_byte          (rx_byte),
    .max_packet_bytes (max_packet_bytes),
    .max_topic_bytes  (max_topic_bytes),
    .res              (par_res),
    .evt              (rx_evt)
  );

  mqttrd_keepalive u_keepalive (
    .clk               (clk),
    .rst               (rst),
    .evt               (ka_evt),
    .keepalive_seconds (keepalive_seconds),
    .res               (ka_res),
    .link_down         (link_down)
  );

  // Only one of the two sources can answer a given transaction.
  assign new_res = par_res.valid ? par_res : ka_res;

  // Output register with a skid register behind it.
  mqttrd_pkg::result_t out_reg;
  mqttrd_pkg::result_t skid;
  logic                skid_valid;
  logic                take;

  assign take     = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= new_res.valid;
      end
    end else if (new_res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      out_reg <= skid_valid ? skid : new_res;
    end
    if (!skid_valid) begin
      skid <= new_res;
    end
  end

  assign kind         = out_reg.kind;
  assign data_byte    = out_reg.data_byte;
  assign topic_length = out_reg.topic_length;
  assign message_end  = out_reg.message_end;

  // Kinds that belong to a delivered publish message.
  logic msg_kind;

  assign msg_kind = kind inside {mqttrd_pkg::KIND_TOPIC, mqttrd_pkg::KIND_PAYLOAD,
                                 mqttrd_pkg::KIND_EMPTY_END};

  `MQTTRD_ASSERT_ALWAYS(a_single_source, !(par_res.valid && ka_res.valid), "two results at once")
  `MQTTRD_ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid full, output empty")
  `MQTTRD_ASSERT_IMPLIES(a_end_kind, out_valid && message_end, msg_kind, "bad end flag")
  `MQTTRD_ASSERT_IMPLIES(a_quiet_when_down, link_down, !new_res.valid, "result while link down")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mqttrd_pkg::*;

  // Parse position of the receive side, kept by the tracker below.
  typedef enum logic [2:0] {
    WAIT_HEADER,
    READ_LENGTH,
    READ_TLEN_HI,
    READ_TLEN_LO,
    STREAM_DATA,
    SKIP_BODY
  } parse_step_t;

  // One delivery on the output channel.
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] tlen;
    logic        last;
  } delivery_t;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 300;

  // Tracks the deframer and keepalive state of the block and holds the
  // deliveries that are still owed on the output channel.
  class deframe_tracker_t;
    delivery_t      owed[$];
    int unsigned    errors;
    logic [15:0]    ka_limit, pkt_limit, topic_limit;
    parse_step_t    step;
    logic [3:0]     pkt_type;
    int unsigned    digits;
    logic [27:0]    body_left;
    logic [15:0]    topic_len, topic_left;
    logic           drop;
    logic [15:0]    idle_in, idle_out;
    logic           ping_out, link_dead;

    function new();
      errors      = 0;
      ka_limit    = KEEPALIVE_RESET;
      pkt_limit   = MAX_PACKET_RESET;
      topic_limit = MAX_TOPIC_RESET;
      clear_link();
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_KEEPALIVE:  ka_limit = val;
        REG_MAX_PACKET: pkt_limit = val;
        REG_MAX_TOPIC:  topic_limit = val;
        default: ;
      endcase
    endfunction

    function void clear_link();
      step       = WAIT_HEADER;
      pkt_type   = '0;
      digits     = 0;
      body_left  = '0;
      topic_len  = '0;
      topic_left = '0;
      drop       = 1'b0;
      idle_in    = '0;
      idle_out   = '0;
      ping_out   = 1'b0;
      link_dead  = 1'b0;
    endfunction

    function void owe(logic [2:0] k, logic [7:0] d, logic [15:0] tl, logic e);
      delivery_t r;
      r.kind = k;
      r.data = d;
      r.tlen = tl;
      r.last = e;
      owed.push_back(r);
    endfunction

    // A packet has been consumed completely outside the streaming path.
    function void close_packet();
      step = WAIT_HEADER;
      if (drop) begin
        drop = 1'b0;
        return;
      end
      idle_in = '0;
      if (pkt_type == TYPE_PINGREQ) owe(KIND_PINGRESP, 8'h00, 16'h0000, 1'b0);
      else if (pkt_type == TYPE_PINGRESP) ping_out = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned total;
      logic [2:0]  k;
      logic        done;
      case (step)
        WAIT_HEADER: begin
          pkt_type  = b[7:4];
          digits    = 0;
          body_left = '0;
          drop      = 1'b0;
          step      = READ_LENGTH;
        end
        READ_LENGTH: begin
          body_left = body_left | (28'(b[6:0]) << (7 * (digits % 4)));
          digits++;
          // The fourth digit closes the length whatever its top bit says.
          if (b[7] && digits < 4) return;
          total = 1 + digits + body_left;
          if (total > pkt_limit) drop = 1'b1;
          if (body_left == 0) begin
            if (!drop && pkt_type == TYPE_PUBLISH) begin
              step    = WAIT_HEADER;
              idle_in = '0;
            end else begin
              close_packet();
            end
            return;
          end
          step = (!drop && pkt_type == TYPE_PUBLISH) ? READ_TLEN_HI : SKIP_BODY;
        end
        READ_TLEN_HI: begin
          topic_len = {b, 8'h00};
          body_left--;
          if (body_left == 0) begin
            step    = WAIT_HEADER;
            idle_in = '0;
          end else begin
            step = READ_TLEN_LO;
          end
        end
        READ_TLEN_LO: begin
          topic_len[7:0] = b;
          body_left--;
          if (topic_len > topic_limit || topic_len > body_left) begin
            if (body_left == 0) begin
              step    = WAIT_HEADER;
              idle_in = '0;
            end else begin
              step = SKIP_BODY;
            end
          end else if (body_left == 0) begin
            step    = WAIT_HEADER;
            idle_in = '0;
            owe(KIND_EMPTY_END, 8'h00, topic_len, 1'b1);
          end else begin
            topic_left = topic_len;
            step       = STREAM_DATA;
          end
        end
        STREAM_DATA: begin
          k = KIND_PAYLOAD;
          if (topic_left > 0) begin
            k = KIND_TOPIC;
            topic_left--;
          end
          body_left--;
          done = (body_left == 0);
          if (done) begin
            step    = WAIT_HEADER;
            idle_in = '0;
          end
          owe(k, b, topic_len, done);
        end
        SKIP_BODY: begin
          if (body_left > 0) body_left--;
          if (body_left == 0) close_packet();
        end
        default: step = WAIT_HEADER;
      endcase
    endfunction

    function void take_tick();
      if (idle_in != 16'hFFFF) idle_in++;
      if (idle_out != 16'hFFFF) idle_out++;
      if (idle_in > ka_limit || idle_out > ka_limit) begin
        if (ping_out) begin
          link_dead = 1'b1;
          owe(KIND_LINK_LOST, 8'h00, 16'h0000, 1'b0);
        end else begin
          idle_in  = '0;
          idle_out = '0;
          ping_out = 1'b1;
          owe(KIND_PINGREQ, 8'h00, 16'h0000, 1'b0);
        end
      end
    endfunction

    function void note_transaction(logic [1:0] opc, logic [7:0] b);
      if (opc == OP_RESTART) begin
        clear_link();
        return;
      end
      if (link_dead) return;
      case (opc)
        OP_RX:   take_byte(b);
        OP_TICK: take_tick();
        OP_SENT: idle_out = '0;
        default: ;
      endcase
    endfunction

    function void report(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] d, logic [15:0] tl, logic e);
      delivery_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0h byte %0h len %0h end %0b",
                 $time, k, d, tl, e);
        return;
      end
      want = owed.pop_front();
      if (k !== want.kind) report("kind", 16'(want.kind), 16'(k));
      if (d !== want.data) report("data_byte", 16'(want.data), 16'(d));
      if (tl !== want.tlen) report("topic_length", want.tlen, tl);
      if (e !== want.last) report("message_end", 16'(want.last), 16'(e));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_RX;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] topic_length;
  logic        message_end;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_KEEPALIVE;
  logic [15:0] cfg_data = 16'h0000;

  deframe_tracker_t tracker = new();

  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  // The sender and the receiver each alternate between idling at random and
  // running flat out; eager forces the sender flat out.
  bit send_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit eager = 1'b0;
  bit hold_request = 1'b0;

  mqtt_receive_deframer_keepalive DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .topic_length (topic_length),
    .message_end  (message_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Every result transaction is compared with the oldest owed delivery.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_result(kind, data_byte, topic_length, message_end);
  end

  // The receiver stalls for a random number of cycles before each result,
  // and for one long stretch when the stimulus asks for it.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        hold = sink_calm ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid && !hold_request);
    end
  end

  function automatic int unsigned pick_gap();
    if (eager) return 0;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    return send_calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Offers one input transaction and returns at the edge that takes it. The
  // valid stays high so that a following transaction with no gap is seamless.
  task automatic send_item(input logic [1:0] opc, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= opc;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    tracker.note_transaction(opc, b);
    items_sent++;
  endtask

  // A link byte, sometimes preceded by a tick or a sent notice so that the
  // keepalive logic is exercised in the middle of a packet.
  task automatic send_rx_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 3)
      send_item($urandom_range(0, 1) ? OP_TICK : OP_SENT, 8'($urandom));
    send_item(OP_RX, b);
  endtask

  task automatic send_length(input int unsigned n);
    int unsigned rest;
    logic [6:0]  digit;
    rest = n;
    do begin
      digit = 7'(rest % 128);
      rest  = rest / 128;
      send_rx_byte({rest != 0, digit});
    end while (rest != 0);
  endtask

  task automatic send_control(input logic [3:0] ptype, input int unsigned n);
    send_rx_byte({ptype, 4'($urandom)});
    send_length(n);
    repeat (n) send_rx_byte(8'($urandom));
  endtask

  // PUBLISH with the given topic length field and rest bytes after it.
  task automatic send_publish(input logic [15:0] tlen, input int unsigned rest);
    send_rx_byte({TYPE_PUBLISH, 4'($urandom)});
    send_length(rest + 2);
    send_rx_byte(tlen[15:8]);
    send_rx_byte(tlen[7:0]);
    repeat (rest) send_rx_byte(8'($urandom));
  endtask

  // Stops offering and waits until every owed delivery has arrived, then waits on
  // for anything the block may still have in its pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_limits(input logic [15:0] ka, input logic [15:0] pkt,
                                input logic [15:0] topic);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEEPALIVE;
    cfg_data  <= ka;
    @(posedge clk);
    cfg_index <= REG_MAX_PACKET;
    cfg_data  <= pkt;
    @(posedge clk);
    cfg_index <= REG_MAX_TOPIC;
    cfg_data  <= topic;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(REG_KEEPALIVE, ka);
    tracker.set_reg(REG_MAX_PACKET, pkt);
    tracker.set_reg(REG_MAX_TOPIC, topic);
  endtask

  // Random traffic, mostly well formed packets with random content, mixed
  // with ticks, sent notices, oversized and malformed packets and noise.
  task automatic run_traffic(input int unsigned target);
    int unsigned pick, tmax, n0, r;
    logic [15:0] tlen;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (tracker.link_dead && $urandom_range(0, 1)) begin
        send_item(OP_RESTART, 8'($urandom));
      end else if (pick < 50) begin
        tmax = (tracker.topic_limit < 6) ? tracker.topic_limit : 6;
        tlen = 16'($urandom_range(0, tmax));
        send_publish(tlen, tlen + $urandom_range(0, 10));
      end else if (pick < 58) begin
        send_control($urandom_range(0, 1) ? TYPE_PINGREQ : TYPE_PINGRESP,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 64) begin
        send_control(4'($urandom), $urandom_range(0, 6));
      end else if (pick < 70) begin
        // Whole size just below, at or just above the packet limit.
        if (tracker.pkt_limit <= 400) begin
          n0 = (tracker.pkt_limit - 2 < 128) ? tracker.pkt_limit - 2 : tracker.pkt_limit - 3;
          r  = n0 - 1 + $urandom_range(0, 2);
          tmax = (tracker.topic_limit < 4) ? tracker.topic_limit : 4;
          if (tmax > r - 2) tmax = r - 2;
          send_publish(16'($urandom_range(0, tmax)), r - 2);
        end else begin
          send_publish(16'($urandom_range(0, 3)), $urandom_range(100, 300));
        end
      end else if (pick < 76) begin
        // Topic longer than allowed or longer than the packet.
        if ($urandom_range(0, 1)) begin
          send_publish(16'($urandom), $urandom_range(0, 8));
        end else if (tracker.topic_limit <= 40) begin
          tlen = tracker.topic_limit + 16'd1;
          send_publish(tlen, tlen + $urandom_range(0, 3));
        end else begin
          tlen = 16'($urandom_range(1, 6));
          send_publish(tlen, tlen - 1);
        end
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom));
      end else if (pick < 91) begin
        send_item(OP_SENT, 8'($urandom));
      end else if (pick < 95) begin
        // Garbage, possibly a broken packet, cleaned up by a restart.
        repeat ($urandom_range(1, 6)) send_item(2'($urandom), 8'($urandom));
        send_item(OP_RESTART, 8'($urandom));
      end else if (pick < 97) begin
        send_item(OP_RESTART, 8'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] opening[$] = {
      // Empty topic and empty payload.
      8'h30, 8'h02, 8'h00, 8'h00,
      // One topic byte and one payload byte, extreme data values.
      8'h3F, 8'h04, 8'h00, 8'h01, 8'hFF, 8'h00,
      // Ping request from the peer.
      8'hC0, 8'h00,
      // Four length digits with the continuation bit still set on the last.
      8'h20, 8'h80, 8'h80, 8'h80, 8'h80,
      // Publish that ends inside the topic length field.
      8'h30, 8'h01, 8'hAB,
      // Topic length larger than the rest of the packet.
      8'h35, 8'h03, 8'h00, 8'h05, 8'h11,
      // Ping response from the peer.
      8'hD0, 8'h00
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with the reset limits.
    foreach (opening[i]) send_item(OP_RX, opening[i]);
    send_item(OP_SENT, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_RESTART, 8'h5A);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering a long message, so the block has to stall.
    hold_request = 1'b1;
    eager = 1'b1;
    send_publish(16'd2, 62);
    eager = 1'b0;
    wait_drained();

    run_traffic(450);
    wait_drained();
    program_limits(16'd1, 16'd5, 16'd0);
    run_traffic(800);
    wait_drained();
    program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(1150);
    wait_drained();
    program_limits(16'($urandom_range(3, 40)), 16'($urandom_range(20, 200)),
                   16'($urandom_range(0, 10)));
    run_traffic(1500);
    wait_drained();
    program_limits(KEEPALIVE_RESET, MAX_PACKET_RESET, MAX_TOPIC_RESET);
    run_traffic(1850);

    // Drain and give the block time to show any stray result.
    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mqttrd_pkg.sv
rtl/mqttrd_parser.sv
rtl/mqttrd_keepalive.sv
rtl/mqtt_receive_deframer_keepalive.sv
tb/sv/tb.sv
